// ===== src/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the mesh support point search
// Item layouts, action codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  localparam int MAX_VERTICES_DEF       = 1024;
  localparam int MAX_NEIGHBOR_SLOTS_DEF = 8192;
  localparam int FRAC_BITS_DEF          = 16;

  localparam int ACC_W   = 66;  // exact sum of three 64-bit products
  localparam int LINK_W  = 14;
  localparam int VCNT_W  = 11;

  localparam logic [2:0] ACT_QUERY    = 3'd0;
  localparam logic [2:0] ACT_VERTEX   = 3'd1;
  localparam logic [2:0] ACT_OFFSET   = 3'd2;
  localparam logic [2:0] ACT_NEIGHBOR = 3'd3;
  localparam logic [2:0] ACT_POSE     = 3'd4;

  localparam logic CFG_VTX_TOTAL   = 1'b0;
  localparam logic CFG_SEARCH_MODE = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [13:0]        index;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [13:0]        link;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] support_x;
    logic signed [31:0] support_y;
    logic signed [31:0] support_z;
    logic [9:0]         support_index;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_op_t;

endpackage

`default_nettype wire

// ===== src/mss_mac.sv =====
// ----------------------------------------------------------------------------
// mss_mac: shared multiply-accumulate unit
// One 32x32 signed product a cycle, registered, then summed into a wide
// accumulator. The first product of a dot product restarts the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_mac (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mss_pkg::mac_op_t               op,
  input  wire logic signed [31:0]             a,
  input  wire logic signed [31:0]             b,
  output logic signed [mss_pkg::ACC_W-1:0]    acc
);

  logic signed [63:0]               prod_r;
  mss_pkg::mac_op_t                 op_r;
  logic signed [mss_pkg::ACC_W-1:0] acc_r;
  logic signed [mss_pkg::ACC_W-1:0] prod_ext;

  assign prod_ext = {{(mss_pkg::ACC_W-64){prod_r[63]}}, prod_r};
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
    prod_r <= a * b;
    if (op_r.valid) begin
      acc_r <= op_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

endmodule

`default_nettype wire

// ===== src/mss_store.sv =====
// ----------------------------------------------------------------------------
// mss_store: mesh memories
// Vertex store, adjacency offsets and neighbour slots, each with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_store #(
  parameter int MAX_VERTICES       = mss_pkg::MAX_VERTICES_DEF,
  parameter int MAX_NEIGHBOR_SLOTS = mss_pkg::MAX_NEIGHBOR_SLOTS_DEF,
  localparam int VIDX_W = $clog2(MAX_VERTICES),
  localparam int OFF_AW = $clog2(MAX_VERTICES + 1),
  localparam int NSL_AW = $clog2(MAX_NEIGHBOR_SLOTS)
) (
  input  wire logic                         clk,
  input  wire logic                         vwr_en,
  input  wire logic [VIDX_W-1:0]            vwr_addr,
  input  wire mss_pkg::vertex_t             vwr_data,
  input  wire logic                         vrd_en,
  input  wire logic [VIDX_W-1:0]            vrd_addr,
  output mss_pkg::vertex_t                  vrd_data,
  input  wire logic                         owr_en,
  input  wire logic [OFF_AW-1:0]            owr_addr,
  input  wire logic [mss_pkg::LINK_W-1:0]   owr_data,
  input  wire logic                         ord_en,
  input  wire logic [OFF_AW-1:0]            ord_addr,
  output logic [mss_pkg::LINK_W-1:0]        ord_data,
  input  wire logic                         nwr_en,
  input  wire logic [NSL_AW-1:0]            nwr_addr,
  input  wire logic [mss_pkg::LINK_W-1:0]   nwr_data,
  input  wire logic                         nrd_en,
  input  wire logic [NSL_AW-1:0]            nrd_addr,
  output logic [mss_pkg::LINK_W-1:0]        nrd_data
);

  mss_pkg::vertex_t            vmem [MAX_VERTICES];
  logic [mss_pkg::LINK_W-1:0]  omem [MAX_VERTICES + 1];
  logic [mss_pkg::LINK_W-1:0]  nmem [MAX_NEIGHBOR_SLOTS];

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= vwr_data;
    end
    if (vrd_en) begin
      vrd_data <= vmem[vrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (owr_en) begin
      omem[owr_addr] <= owr_data;
    end
    if (ord_en) begin
      ord_data <= omem[ord_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      nmem[nwr_addr] <= nwr_data;
    end
    if (nrd_en) begin
      nrd_data <= nmem[nrd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/mesh_support_point_search.sv =====
// ----------------------------------------------------------------------------
// mesh_support_point_search: support point of a posed convex vertex mesh
// Load words fill the mesh and pose; a query word returns the support point.
// ----------------------------------------------------------------------------
// Input words are taken on start while busy is low. Action 1..4 words write
// a vertex, an offset, a neighbour slot or a pose element and finish in the
// cycle they are taken, giving no result. A query word raises busy until its
// result has been issued. The result appears on out_item for exactly one
// cycle with out_valid high; the receiver cannot stall it.
// All multiplication runs through one shared 32x32 multiplier, which takes
// one product a cycle.
// Configuration writes on the cfg_ channel are always ready and take effect
// at once; write them only while idle. Reset restores identity rotation,
// zero translation, a vertex count of 1, linear mode and last vertex 0; the
// mesh memories are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_support_point_search #(
  parameter int MAX_VERTICES       = mss_pkg::MAX_VERTICES_DEF,
  parameter int MAX_NEIGHBOR_SLOTS = mss_pkg::MAX_NEIGHBOR_SLOTS_DEF,
  parameter int FRAC_BITS          = mss_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire mss_pkg::in_item_t          in_item,
  output logic                            out_valid,
  output mss_pkg::out_item_t              out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [mss_pkg::VCNT_W-1:0] cfg_data
);

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int OFF_AW = $clog2(MAX_VERTICES + 1);
  localparam int NSL_AW = $clog2(MAX_NEIGHBOR_SLOTS);
  localparam int ROT_W  = FRAC_BITS + 2;
  localparam int ACC_W  = mss_pkg::ACC_W;
  localparam int LINK_W = mss_pkg::LINK_W;
  localparam logic signed [31:0] ROT_HI = 32'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [31:0] ROT_LO = -ROT_HI - 32'sd1;
  localparam logic [ROT_W-1:0]   ROT_ONE = ROT_W'(1 << FRAC_BITS);
  localparam logic [ACC_W:0]     HALF = (ACC_W+1)'(1 << (FRAC_BITS - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_DIR, S_VRD, S_VDOT, S_ORD0, S_ORD1, S_ORD2,
    S_NCHK, S_NGET, S_WRD, S_WDOT, S_OUT
  } state_t;

  state_t                  state_r;
  logic [2:0]              k_r;
  logic [1:0]              comp_r;
  logic [ROT_W-1:0]        rot_r [9];
  logic signed [31:0]      trans_r [3];
  logic signed [31:0]      d_r [3];
  logic signed [31:0]      dir_r [3];
  logic signed [31:0]      world_r [3];
  logic [VIDX_W-1:0]       last_r;
  logic [VIDX_W-1:0]       cand_r;
  logic [VIDX_W-1:0]       best_r;
  logic signed [ACC_W-1:0] bs_r;
  logic                    first_r;
  logic                    moved_r;
  logic                    sat_r;
  logic [LINK_W-1:0]       slot_r;
  logic [LINK_W-1:0]       end_r;
  logic [mss_pkg::VCNT_W-1:0] vcount_r;
  logic                    mode_r;
  logic                    out_valid_r;
  mss_pkg::out_item_t      out_item_r;

  logic                    take;
  logic [31:0]             idx_wide;
  logic [31:0]             n_wide;
  logic [VIDX_W-1:0]       start_vtx;
  logic [3:0]              rot_sel;
  logic [ROT_W-1:0]        rot_val;
  logic signed [31:0]      rot_ext;
  logic signed [31:0]      vcoord;
  logic signed [31:0]      mac_a;
  logic signed [31:0]      mac_b;
  mss_pkg::mac_op_t        mac_op;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W:0]   rnd_ext;
  logic signed [ACC_W:0]   rnd_sum;
  logic signed [31:0]      rnd_val;
  logic                    rnd_sat;
  logic                    better;
  logic                    nb_ok;
  logic [31:0]             nb_wide;
  logic [31:0]             cand_wide;
  logic [31:0]             best_wide;
  logic [31:0]             best1_wide;
  logic [31:0]             slot_wide;
  logic signed [31:0]      rot_clamp;

  mss_pkg::vertex_t        vwr_data;
  mss_pkg::vertex_t        vrd_data;
  logic                    vwr_en, vrd_en, owr_en, ord_en, nwr_en, nrd_en;
  logic [VIDX_W-1:0]       vrd_addr;
  logic [OFF_AW-1:0]       ord_addr;
  logic [LINK_W-1:0]       ord_data;
  logic [LINK_W-1:0]       nrd_data;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign take      = start && !busy;
  assign idx_wide  = 32'(in_item.index);

  // vertices in use: zero counts as one, capped at the store size
  always_comb begin
    if (vcount_r == '0) begin
      n_wide = 32'd1;
    end else if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_wide = 32'(MAX_VERTICES);
    end else begin
      n_wide = 32'(vcount_r);
    end
  end

  assign start_vtx  = (32'(last_r) < n_wide) ? last_r : '0;
  assign nb_wide    = 32'(nrd_data);
  assign nb_ok      = nb_wide < n_wide;
  assign cand_wide  = 32'(cand_r);
  assign best_wide  = 32'(best_r);
  assign best1_wide = best_wide + 32'd1;
  assign slot_wide  = 32'(slot_r);

  // memory control
  assign vwr_data = '{x: in_item.value_x, y: in_item.value_y, z: in_item.value_z};
  assign vwr_en   = take && (in_item.action == mss_pkg::ACT_VERTEX)
                    && (idx_wide < 32'(MAX_VERTICES));
  assign owr_en   = take && (in_item.action == mss_pkg::ACT_OFFSET)
                    && (idx_wide <= 32'(MAX_VERTICES));
  assign nwr_en   = take && (in_item.action == mss_pkg::ACT_NEIGHBOR)
                    && (idx_wide < 32'(MAX_NEIGHBOR_SLOTS));
  assign vrd_en   = (state_r == S_VRD) || (state_r == S_WRD)
                    || ((state_r == S_NGET) && nb_ok);
  assign ord_en   = (state_r == S_ORD0) || (state_r == S_ORD1);
  assign nrd_en   = (state_r == S_NCHK) && (slot_r < end_r);
  assign ord_addr = (state_r == S_ORD1) ? best1_wide[OFF_AW-1:0] : best_wide[OFF_AW-1:0];

  always_comb begin
    case (state_r)
      S_VRD:   vrd_addr = cand_r;
      S_NGET:  vrd_addr = nb_wide[VIDX_W-1:0];
      default: vrd_addr = best_r;
    endcase
  end

  mss_store #(
    .MAX_VERTICES       (MAX_VERTICES),
    .MAX_NEIGHBOR_SLOTS (MAX_NEIGHBOR_SLOTS)
  ) u_store (
    .clk      (clk),
    .vwr_en   (vwr_en),
    .vwr_addr (idx_wide[VIDX_W-1:0]),
    .vwr_data (vwr_data),
    .vrd_en   (vrd_en),
    .vrd_addr (vrd_addr),
    .vrd_data (vrd_data),
    .owr_en   (owr_en),
    .owr_addr (idx_wide[OFF_AW-1:0]),
    .owr_data (in_item.link),
    .ord_en   (ord_en),
    .ord_addr (ord_addr),
    .ord_data (ord_data),
    .nwr_en   (nwr_en),
    .nwr_addr (idx_wide[NSL_AW-1:0]),
    .nwr_data (in_item.link),
    .nrd_en   (nrd_en),
    .nrd_addr (slot_wide[NSL_AW-1:0]),
    .nrd_data (nrd_data)
  );

  // operand selection for the shared multiplier
  always_comb begin
    if (state_r == S_WDOT) begin
      rot_sel = ({2'b00, comp_r} * 4'd3) + {2'b00, k_r[1:0]};
    end else begin
      rot_sel = ({2'b00, k_r[1:0]} * 4'd3) + {2'b00, comp_r};
    end
    rot_val = (rot_sel < 4'd9) ? rot_r[rot_sel] : '0;
    rot_ext = {{(32-ROT_W){rot_val[ROT_W-1]}}, rot_val};
    case (k_r)
      3'd0:    vcoord = vrd_data.x;
      3'd1:    vcoord = vrd_data.y;
      default: vcoord = vrd_data.z;
    endcase
    case (state_r)
      S_DIR: begin
        mac_a = rot_ext;
        mac_b = (k_r < 3'd3) ? d_r[k_r[1:0]] : '0;
      end
      S_VDOT: begin
        mac_a = vcoord;
        mac_b = (k_r < 3'd3) ? dir_r[k_r[1:0]] : '0;
      end
      default: begin
        mac_a = rot_ext;
        mac_b = vcoord;
      end
    endcase
    mac_op.valid = ((state_r == S_DIR) || (state_r == S_VDOT) || (state_r == S_WDOT))
                   && (k_r < 3'd3);
    mac_op.first = (k_r == 3'd0);
  end

  mss_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  // round to nearest (ties up), add translation on the way out, saturate
  always_comb begin
    rnd_ext = ($signed({acc[ACC_W-1], acc}) + $signed(HALF)) >>> FRAC_BITS;
    if ((state_r == S_WDOT) && (comp_r < 2'd3)) begin
      rnd_sum = rnd_ext + {{(ACC_W-31){trans_r[comp_r][31]}}, trans_r[comp_r]};
    end else begin
      rnd_sum = rnd_ext;
    end
    rnd_sat = !((&rnd_sum[ACC_W:31]) || !(|rnd_sum[ACC_W:31]));
    if (!rnd_sat) begin
      rnd_val = rnd_sum[31:0];
    end else if (rnd_sum[ACC_W]) begin
      rnd_val = 32'sh8000_0000;
    end else begin
      rnd_val = 32'sh7FFF_FFFF;
    end
    better = first_r || (acc > bs_r);
    if (in_item.value_x > ROT_HI) begin
      rot_clamp = ROT_HI;
    end else if (in_item.value_x < ROT_LO) begin
      rot_clamp = ROT_LO;
    end else begin
      rot_clamp = in_item.value_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      vcount_r    <= mss_pkg::VCNT_W'(1);
      mode_r      <= 1'b0;
      first_r     <= 1'b0;
      moved_r     <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rot_r[i] <= (i % 4 == 0) ? ROT_ONE : '0;
      end
      for (int i = 0; i < 3; i++) begin
        trans_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == mss_pkg::CFG_VTX_TOTAL) begin
          vcount_r <= cfg_data;
        end else begin
          mode_r <= cfg_data[0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (take && (in_item.action == mss_pkg::ACT_POSE)) begin
            if (idx_wide < 32'd9) begin
              rot_r[idx_wide[3:0]] <= rot_clamp[ROT_W-1:0];
            end else if (idx_wide < 32'd12) begin
              trans_r[2'(idx_wide - 32'd9)] <= in_item.value_x;
            end
          end
          if (take && (in_item.action == mss_pkg::ACT_QUERY)) begin
            d_r[0]  <= in_item.value_x;
            d_r[1]  <= in_item.value_y;
            d_r[2]  <= in_item.value_z;
            sat_r   <= 1'b0;
            k_r     <= '0;
            comp_r  <= '0;
            state_r <= S_DIR;
          end
        end
        S_DIR: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd4) begin
            k_r            <= '0;
            dir_r[comp_r]  <= rnd_val;
            sat_r          <= sat_r | rnd_sat;
            if (comp_r == 2'd2) begin
              comp_r  <= '0;
              cand_r  <= mode_r ? start_vtx : '0;
              first_r <= 1'b1;
              state_r <= S_VRD;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        S_VRD: begin
          k_r     <= '0;
          state_r <= S_VDOT;
        end
        S_VDOT: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd4) begin
            k_r     <= '0;
            first_r <= 1'b0;
            if (better) begin
              bs_r   <= acc;
              best_r <= cand_r;
              if (!first_r) begin
                moved_r <= 1'b1;
              end
            end
            if (!mode_r) begin
              if (cand_wide + 32'd1 < n_wide) begin
                cand_r  <= cand_r + VIDX_W'(1);
                state_r <= S_VRD;
              end else begin
                state_r <= S_WRD;
              end
            end else if (first_r) begin
              state_r <= S_ORD0;
            end else begin
              slot_r  <= slot_r + LINK_W'(1);
              state_r <= S_NCHK;
            end
          end
        end
        S_ORD0: begin
          state_r <= S_ORD1;
        end
        S_ORD1: begin
          slot_r  <= ord_data;
          state_r <= S_ORD2;
        end
        S_ORD2: begin
          // clip the list end to the slot memory
          if (32'(ord_data) > 32'(MAX_NEIGHBOR_SLOTS)) begin
            end_r <= LINK_W'(MAX_NEIGHBOR_SLOTS);
          end else begin
            end_r <= ord_data;
          end
          moved_r <= 1'b0;
          state_r <= S_NCHK;
        end
        S_NCHK: begin
          if (slot_r < end_r) begin
            state_r <= S_NGET;
          end else if (moved_r) begin
            state_r <= S_ORD0;
          end else begin
            comp_r  <= '0;
            state_r <= S_WRD;
          end
        end
        S_NGET: begin
          if (nb_ok) begin
            cand_r  <= nb_wide[VIDX_W-1:0];
            k_r     <= '0;
            state_r <= S_VDOT;
          end else begin
            slot_r  <= slot_r + LINK_W'(1);
            state_r <= S_NCHK;
          end
        end
        S_WRD: begin
          k_r     <= '0;
          comp_r  <= '0;
          state_r <= S_WDOT;
        end
        S_WDOT: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd4) begin
            k_r             <= '0;
            world_r[comp_r] <= rnd_val;
            sat_r           <= sat_r | rnd_sat;
            if (comp_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        S_OUT: begin
          out_valid_r                <= 1'b1;
          out_item_r.support_x       <= world_r[0];
          out_item_r.support_y       <= world_r[1];
          out_item_r.support_z       <= world_r[2];
          out_item_r.support_index   <= best_wide[9:0];
          out_item_r.saturated       <= sat_r;
          if (mode_r) begin
            last_r <= best_r;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/mesh_support_point_search_tb.sv =====
// ----------------------------------------------------------------------------
// mesh_support_point_search_tb: self-checking bench for the mesh support search
// A directed table covers reset pose, extreme values, rotation clamping and
// ignored words. Random phases then load a ring mesh and mix queries with
// mesh and pose writes in linear and hill-climb mode, under random start gaps.
// Each result is compared field by field against an internal predictor.
// ----------------------------------------------------------------------------
module mesh_support_point_search_tb;

  localparam int          NVERT      = 1024;
  localparam int          NSLOT      = 8192;
  localparam int          NPRE       = 40;
  localparam int          FRAC       = 16;
  localparam int          IDLE_LIMIT = 100000;
  localparam logic [10:0] MODE_LINEAR = 11'd0;
  localparam logic [10:0] MODE_HILL   = 11'd1;

  typedef struct {
    mss_pkg::in_item_t  word;
    bit                 typed;
    mss_pkg::out_item_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  mss_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  mss_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [10:0]        cfg_data = '0;

  mesh_support_point_search uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  mss_pkg::vertex_t mesh_vtx [NVERT];
  int          mesh_off [NVERT+1];
  int          mesh_nbr [NSLOT];
  int          rot [9];
  int          trans [3];
  int          last_v;
  logic [10:0] vcount;
  logic [10:0] mode;

  mss_pkg::out_item_t support_due [$];
  int          errors = 0;
  int          results_seen = 0;
  int          load_words = 0;
  int          settings_run = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int          slots_loaded = 0;

  function automatic int count_in_use();
    if (vcount == 0) return 1;
    if (vcount > NVERT) return NVERT;
    return int'(vcount);
  endfunction

  function automatic longint round_q(input longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic int clamp32(input longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  function automatic logic signed [65:0] score(input mss_pkg::vertex_t p, input int dx, dy, dz);
    logic signed [65:0] px, py, pz, qx, qy, qz;
    px = p.x; py = p.y; pz = p.z;
    qx = dx;  qy = dy;  qz = dz;
    return px * qx + py * qy + pz * qz;
  endfunction

  // apply one accepted word; queue the support point it yields, if any
  task automatic predict_support(input mss_pkg::in_item_t w);
    int                 dir [3];
    int                 n, best, b, e, k, nb;
    bit                 s;
    bit                 moved;
    longint             acc;
    logic signed [65:0] bs, sc;
    mss_pkg::out_item_t r;
    s = 1'b0;
    case (w.action)
      mss_pkg::ACT_VERTEX:
        if (w.index < NVERT) mesh_vtx[w.index] = '{w.value_x, w.value_y, w.value_z};
      mss_pkg::ACT_OFFSET: if (w.index <= NVERT) mesh_off[w.index] = w.link;
      mss_pkg::ACT_NEIGHBOR: if (w.index < NSLOT) mesh_nbr[w.index] = w.link;
      mss_pkg::ACT_POSE: begin
        if (w.index < 9) begin
          if (w.value_x > 131071) rot[w.index] = 131071;
          else if (w.value_x < -131072) rot[w.index] = -131072;
          else rot[w.index] = w.value_x;
        end else if (w.index < 12) begin
          trans[w.index-9] = w.value_x;
        end
      end
      mss_pkg::ACT_QUERY: begin
        for (int i = 0; i < 3; i++) begin
          acc = longint'(rot[i]) * w.value_x + longint'(rot[3+i]) * w.value_y
              + longint'(rot[6+i]) * w.value_z;
          dir[i] = clamp32(round_q(acc), s);
        end
        n = count_in_use();
        if (mode == MODE_LINEAR) begin
          best = 0;
          bs = score(mesh_vtx[0], dir[0], dir[1], dir[2]);
          for (int i = 1; i < n; i++) begin
            sc = score(mesh_vtx[i], dir[0], dir[1], dir[2]);
            if (sc > bs) begin
              bs = sc;
              best = i;
            end
          end
        end else begin
          best = (last_v < n) ? last_v : 0;
          bs = score(mesh_vtx[best], dir[0], dir[1], dir[2]);
          moved = 1'b1;
          while (moved) begin
            moved = 1'b0;
            b = mesh_off[best];
            e = mesh_off[best+1];
            if (e > NSLOT) e = NSLOT;
            for (k = b; k < e; k++) begin
              nb = mesh_nbr[k];
              if (nb < n) begin
                sc = score(mesh_vtx[nb], dir[0], dir[1], dir[2]);
                if (sc > bs) begin
                  bs = sc;
                  best = nb;
                  moved = 1'b1;
                end
              end
            end
          end
          last_v = best;
        end
        for (int i = 0; i < 3; i++) begin
          acc = longint'(rot[3*i]) * mesh_vtx[best].x + longint'(rot[3*i+1]) * mesh_vtx[best].y
              + longint'(rot[3*i+2]) * mesh_vtx[best].z;
          dir[i] = clamp32(round_q(acc) + trans[i], s);
        end
        r.support_x = dir[0];
        r.support_y = dir[1];
        r.support_z = dir[2];
        r.support_index = best[9:0];
        r.saturated = s;
        support_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // drive one word; hold start through back-to-back words
  task automatic issue(input mss_pkg::in_item_t w);
    int gap;
    bit took;
    gap = (!calm && $urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    // sample busy away from the edge, then advance to the accepting edge
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    predict_support(w);
    if (w.action != mss_pkg::ACT_QUERY) load_words++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (support_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mss_pkg::CFG_VTX_TOTAL) vcount = data;
    else mode = data;
  endtask

  function automatic int rnd_val();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return int'($urandom_range(0, 2097152)) - 1048576;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic mss_pkg::in_item_t word(input logic [2:0] a, input int idx,
                                             input int x, y, z, input int lnk);
    mss_pkg::in_item_t w;
    w.action = a; w.index = idx[13:0];
    w.value_x = x; w.value_y = y; w.value_z = z;
    w.link = lnk[13:0];
    return w;
  endfunction

  function automatic row_t plain(input mss_pkg::in_item_t w);
    row_t r;
    r.word = w; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic row_t known(input mss_pkg::in_item_t w, input int x, y, z, input bit s);
    row_t r;
    r.word = w; r.typed = 1'b1;
    r.want.support_x = x; r.want.support_y = y; r.want.support_z = z;
    r.want.support_index = '0; r.want.saturated = s;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (support_due.size() == 0) begin
        report("unexpected result word", 1, 0);
      end else begin
        mss_pkg::out_item_t w;
        w = support_due.pop_front();
        results_seen++;
        if (out_item.support_x != w.support_x) report("support_x", out_item.support_x, w.support_x);
        if (out_item.support_y != w.support_y) report("support_y", out_item.support_y, w.support_y);
        if (out_item.support_z != w.support_z) report("support_z", out_item.support_z, w.support_z);
        if (out_item.support_index != w.support_index)
          report("support_index", out_item.support_index, w.support_index);
        if (out_item.saturated != w.saturated) report("saturated", out_item.saturated, w.saturated);
      end
    end
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", support_due.size());
        $display("mesh_support_point_search_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    row_t              rows [$];
    int                counts [11];
    int                modes [11];
    int                quota [11];
    int                n, sent, pick, idx, val;
    mss_pkg::in_item_t w;

    counts = '{4, 0, 16, 8, 37, 3, 1, 40, 24, 5, 12};
    modes  = '{1, 1, 1, 0, 1, 1, 0, 0, 1, 0, 1};
    quota  = '{30, 10, 50, 30, 60, 30, 10, 30, 50, 30, 50};
    for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? 65536 : 0;
    trans  = '{0, 0, 0};
    last_v = 0;
    vcount = 11'd1;
    mode   = MODE_LINEAR;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset pose, one vertex, linear scan
    rows.push_back(plain(word(mss_pkg::ACT_VERTEX, 0, 1, 2, 3, 0)));
    rows.push_back(known(word(mss_pkg::ACT_QUERY, 0, 65536, 0, 0, 0), 1, 2, 3, 1'b0));
    rows.push_back(plain(word(mss_pkg::ACT_VERTEX, 0, 32'h7fffffff, 32'h80000000, 0, 0)));
    rows.push_back(known(word(mss_pkg::ACT_QUERY, 0, 1, 1, 1, 0),
                         32'h7fffffff, 32'h80000000, 0, 1'b0));
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 9, 1, 0, 0, 0)));
    rows.push_back(known(word(mss_pkg::ACT_QUERY, 0, 0, 0, 0, 0),
                         32'h7fffffff, 32'h80000000, 0, 1'b1));
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 9, 0, 0, 0, 0)));
    rows.push_back(known(word(mss_pkg::ACT_QUERY, 0, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 0),
                         32'h7fffffff, 32'h80000000, 0, 1'b0));
    // rotation entries clamp silently; the products then saturate
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 0, 32'h7fffffff, 0, 0, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_QUERY, 0, 32'h7fffffff, 0, 0, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 0, 32'h80000000, 0, 0, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_QUERY, 0, 32'h7fffffff, 5, -5, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 0, 65536, 0, 0, 0)));
    // out-of-range and unknown words must leave state alone
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 12, -1, -1, -1, 16383)));
    rows.push_back(plain(word(mss_pkg::ACT_POSE, 16383, 7, 0, 0, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_VERTEX, 1024, -1, -1, -1, 16383)));
    rows.push_back(plain(word(mss_pkg::ACT_VERTEX, 16383, -1, -1, -1, 0)));
    rows.push_back(plain(word(mss_pkg::ACT_OFFSET, 1025, 0, 0, 0, 16383)));
    rows.push_back(plain(word(mss_pkg::ACT_NEIGHBOR, 8192, 0, 0, 0, 16383)));
    rows.push_back(plain(word(3'd5, 0, -1, -1, -1, 16383)));
    rows.push_back(plain(word(3'd6, 16383, 0, 0, 0, 0)));
    rows.push_back(plain(word(3'd7, 1, 1, 1, 1, 1)));
    rows.push_back(known(word(mss_pkg::ACT_QUERY, 0, -1, -1, -1, 0),
                         32'h7fffffff, 32'h80000000, 0, 1'b0));

    foreach (rows[i]) begin
      issue(rows[i].word);
      if (rows[i].typed) support_due[$] = rows[i].want;
    end
    settle();

    // vertices reached by the widest scans below
    for (int i = 0; i < NPRE; i++) begin
      issue(word(mss_pkg::ACT_VERTEX, i, rnd_val(), rnd_val(), rnd_val(), 0));
    end

    for (int ph = 0; ph < 11; ph++) begin
      settle();
      cfg_write(mss_pkg::CFG_VTX_TOTAL, counts[ph][10:0]);
      cfg_write(mss_pkg::CFG_SEARCH_MODE, modes[ph] ? MODE_HILL : MODE_LINEAR);
      settings_run++;
      n = count_in_use();
      calm = (ph == 2);
      if (mode == MODE_HILL) begin
        // ring adjacency: each vertex sees its two neighbours
        for (int i = 0; i <= n; i++) issue(word(mss_pkg::ACT_OFFSET, i, 0, 0, 0, 2 * i));
        for (int i = 0; i < n; i++) begin
          issue(word(mss_pkg::ACT_NEIGHBOR, 2 * i, 0, 0, 0, (i + 1) % n));
          issue(word(mss_pkg::ACT_NEIGHBOR, 2 * i + 1, 0, 0, 0, (i + n - 1) % n));
        end
        if (2 * n > slots_loaded) slots_loaded = 2 * n;
      end
      sent = 0;
      while (sent < quota[ph]) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          w = word(mss_pkg::ACT_QUERY, $urandom_range(0, 16383), rnd_val(), rnd_val(),
                   rnd_val(), $urandom_range(0, 16383));
          sent++;
        end else if (pick < 70) begin
          w = word(mss_pkg::ACT_VERTEX, $urandom_range(0, n - 1), rnd_val(), rnd_val(),
                   rnd_val(), $urandom_range(0, 16383));
        end else if (pick < 78) begin
          val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - 1) : $urandom_range(0, 16383);
          w = word(mss_pkg::ACT_NEIGHBOR, $urandom_range(0, slots_loaded - 1), 0, 0, 0, val);
        end else if (pick < 84) begin
          idx = $urandom_range(0, n);
          val = $urandom_range(0, slots_loaded);
          // only the first list may start past the slot table
          if (idx == 0 && $urandom_range(0, 3) == 0) val = $urandom_range(8192, 16383);
          w = word(mss_pkg::ACT_OFFSET, idx, 0, 0, 0, val);
        end else if (pick < 94) begin
          idx = $urandom_range(0, 11);
          if (idx < 9) begin
            case ($urandom_range(0, 6))
              0: val = rnd_val();
              1: val = int'($urandom_range(0, 262143)) - 131072;
              default: val = int'($urandom_range(0, 131072)) - 65536;
            endcase
          end else begin
            val = rnd_val();
          end
          w = word(mss_pkg::ACT_POSE, idx, val, rnd_val(), rnd_val(), 0);
        end else begin
          case ($urandom_range(0, 4))
            0: w = word(mss_pkg::ACT_VERTEX, $urandom_range(1024, 16383), rnd_val(), 0, 0, 0);
            1: w = word(mss_pkg::ACT_OFFSET, $urandom_range(1025, 16383), 0, 0, 0,
                        $urandom_range(0, 16383));
            2: w = word(mss_pkg::ACT_NEIGHBOR, $urandom_range(8192, 16383), 0, 0, 0,
                        $urandom_range(0, 16383));
            3: w = word(mss_pkg::ACT_POSE, $urandom_range(12, 16383), rnd_val(), 0, 0, 0);
            default: w = word(3'($urandom_range(5, 7)), $urandom_range(0, 16383), rnd_val(),
                              rnd_val(), rnd_val(), $urandom_range(0, 16383));
          endcase
        end
        issue(w);
      end
    end

    calm = 1'b0;
    settle();
    repeat (50) @(posedge clk);
    if (support_due.size() != 0) begin
      report("results never arrived", support_due.size(), 0);
    end
    $display("covered %0d support results over %0d register settings", results_seen, settings_run);
    $display("and %0d load or ignored words, %0d mismatches", load_words, errors);
    if (errors == 0) begin
      $display("mesh_support_point_search_tb: clean");
    end else begin
      $display("mesh_support_point_search_tb: errors");
    end
    $finish;
  end

endmodule
